/* design/pre_pkg.sv */
package pre_pkg;

    localparam int FRAMES_DEF    = 64;
    localparam int PAGE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 8;
    localparam int AGE_BITS_DEF  = 32;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 6;
    localparam int SEED_W  = 16;
    localparam int MODE_W  = 3;
    localparam int IDX_W   = 1;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_RST  = 16'h0001;

    typedef enum logic [MODE_W-1:0] {
        POL_NRU    = 3'd0,
        POL_COUNT  = 3'd1,
        POL_AGING  = 3'd2,
        POL_FIFO   = 3'd3,
        POL_CLOCK  = 3'd4,
        POL_RANDOM = 3'd5
    } t_policy;

    localparam logic [IDX_W-1:0] REG_POLICY = 1'b0;
    localparam logic [IDX_W-1:0] REG_SEED   = 1'b1;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [PAGE_W-1:0]     page_number;
        logic                  is_write;
    } t_req;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_W-1:0]    frame_index;
        logic                  evicted_valid;
        logic [PAGE_W-1:0]     evicted_page;
        logic                  evicted_dirty;
    } t_rsp;

    typedef struct packed {
        logic [IDX_W-1:0]      index;
        logic [SEED_W-1:0]     data;
    } t_cfg;

endpackage

/* design/pre_if.sv */
interface pre_req_if;
    logic              valid;
    logic              ready;
    pre_pkg::t_req     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pre_rsp_if;
    logic              valid;
    logic              ready;
    pre_pkg::t_rsp     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pre_cfg_if;
    logic              valid;
    logic              ready;
    pre_pkg::t_cfg     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/pre_ram.sv */
module pre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/page_replacement_engine_unit.sv */
// Page replacement engine: a fully associative table of FRAMES frames with
// NRU, least-count, aging, FIFO, second-chance and random replacement.
// Items (cmd 0 access, cmd 1 tick) are handled one at a time. A sequencer
// scans the frame table one frame per cycle; the least-count and aging
// scans share one compare unit. After reset a clearing pass over every
// frame zeroes the counter and age RAM, and the block is not ready during it.
// An access first scans the tag RAM for its page. A hit then reads the
// frame's counter and age, updates them as the policy needs and sets its
// flags. A miss that finds a free frame fills it.
// A miss with the table full first chooses a victim, then reads its old tag:
//   FIFO and random: the hand or the next LFSR value, with no scan.
//   NRU: a scan that stops early at a clean unreferenced frame.
//   second chance: a sweep of the hand that stops at an unreferenced frame.
//   least count and aging: a scan of all frames.
// A tick sweeps all frames.
// The page tags sit in one RAM. The use counters and aging registers sit
// in a second RAM, each with one read and one write port. Used, referenced
// and modified bits are flip-flops that reset clears.
// An access answers with one item; a tick with none. The input side is not
// ready until the item is finished and any result has been handed over.
module page_replacement_engine_unit #(
    parameter int FRAMES     = pre_pkg::FRAMES_DEF,
    parameter int PAGE_BITS  = pre_pkg::PAGE_BITS_DEF,
    parameter int COUNT_BITS = pre_pkg::COUNT_BITS_DEF,
    parameter int AGE_BITS   = pre_pkg::AGE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pre_req_if.sink   req,
    pre_rsp_if.source rsp,
    pre_cfg_if.sink   cfg
);
    localparam int FW = $clog2(FRAMES);
    localparam int CW = FW + 1;   // scan counter, can hold FRAMES
    localparam int MW = COUNT_BITS + AGE_BITS;
    localparam int VW = (COUNT_BITS > AGE_BITS) ? COUNT_BITS : AGE_BITS;
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_HIT, S_HITWR, S_FREE, S_VSCAN, S_CLOCK,
        S_RDOLD, S_LOAD, S_TICK, S_OUT
    } t_state;

    t_state                r_state;
    logic [pre_pkg::MODE_W-1:0] r_mode;
    logic [pre_pkg::SEED_W-1:0] r_lfsr;
    logic [FW-1:0]         r_hand;

    logic [FRAMES-1:0]     r_used, r_ref, r_mod;

    pre_pkg::t_req         r_req;
    logic [PAGE_BITS-1:0]  r_page;
    logic [CW-1:0]         r_i;       // scan index
    logic [FW-1:0]         r_ridx;    // index of data now on RAM output
    logic                  r_rvld;
    logic [FW-1:0]         r_best;
    logic [VW-1:0]         r_bestv;
    logic [1:0]            r_bcls;    // NRU: best class found so far
    logic                  r_bany;
    logic [FW-1:0]         r_f;
    logic                  r_evict;
    pre_pkg::t_rsp         r_rsp;

    // tag RAM
    logic                  ram_we;
    logic [FW-1:0]         ram_raddr;
    logic [PAGE_BITS-1:0]  ram_rdata;

    pre_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_tags (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_f),
        .i_wdata (r_page),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_we    = (r_state == S_LOAD);
    assign ram_raddr = (r_state == S_RDOLD) ? r_f : r_i[FW-1:0];

    // counter and age RAM, {count, age} per frame
    logic                  meta_we;
    logic [FW-1:0]         meta_waddr;
    logic [MW-1:0]         meta_wdata;
    logic [FW-1:0]         meta_raddr;
    logic [MW-1:0]         meta_rdata;
    logic [COUNT_BITS-1:0] meta_cnt;
    logic [AGE_BITS-1:0]   meta_age;

    pre_ram #(.WIDTH(MW), .DEPTH(FRAMES)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    assign meta_cnt   = meta_rdata[MW-1:AGE_BITS];
    assign meta_age   = meta_rdata[AGE_BITS-1:0];
    assign meta_raddr = (r_state == S_HIT) ? r_f : r_i[FW-1:0];

    assign req.ready = (r_state == S_IDLE);
    assign cfg.ready = (r_state == S_IDLE);
    assign rsp.valid = (r_state == S_OUT);
    assign rsp.payload = r_rsp;

    // ticks leave FIFO and random state alone
    logic tick_clr;
    assign tick_clr = (r_mode != pre_pkg::POL_FIFO) && (r_mode != pre_pkg::POL_RANDOM);

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_f;
        meta_wdata = {meta_cnt, meta_age};
        case (r_state)
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = r_i[FW-1:0];
                meta_wdata = '0;
            end
            S_TICK: begin
                meta_we    = r_rvld && tick_clr;
                meta_waddr = r_ridx;
                meta_wdata = {COUNT_BITS'(0), meta_age >> 1};
            end
            S_HITWR: begin
                if (r_mode == pre_pkg::POL_COUNT) begin
                    meta_we    = 1'b1;
                    meta_wdata = {meta_cnt + COUNT_BITS'(1), meta_age};
                end else if (r_mode == pre_pkg::POL_AGING) begin
                    meta_we    = 1'b1;
                    meta_wdata = {meta_cnt, (meta_age >> 1) | AGE_TOP};
                end
            end
            S_LOAD: begin
                meta_we    = 1'b1;
                meta_wdata = {COUNT_BITS'(1), AGE_TOP};
            end
            default: meta_we = 1'b0;
        endcase
    end

    // first free frame, a priority encode over the used bits
    logic [FW-1:0] free_idx;
    logic          free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int k = FRAMES - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_idx = FW'(k);
                free_any = 1'b1;
            end
        end
    end

    // shared compare unit: value on the RAM output against best so far
    logic [VW-1:0] cur_v;
    logic          less;
    logic [1:0]    cur_cls;
    always_comb begin
        if (r_mode == pre_pkg::POL_COUNT) begin
            cur_v = VW'(meta_cnt);
        end else begin
            cur_v = VW'(meta_age);
        end
        less    = cur_v < r_bestv;
        cur_cls = {r_ref[r_i[FW-1:0]], r_mod[r_i[FW-1:0]]};
    end

    logic [pre_pkg::SEED_W-1:0] lfsr_nx;
    assign lfsr_nx = r_lfsr[0] ? ((r_lfsr >> 1) ^ pre_pkg::LFSR_TAPS) : (r_lfsr >> 1);

    logic is_nru;
    assign is_nru = !(r_mode inside {pre_pkg::POL_COUNT, pre_pkg::POL_AGING,
                                     pre_pkg::POL_FIFO, pre_pkg::POL_CLOCK,
                                     pre_pkg::POL_RANDOM});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_i     <= '0;
            r_mode  <= '0;
            r_lfsr  <= pre_pkg::SEED_RST;
            r_hand  <= '0;
            r_used  <= '0;
            r_ref   <= '0;
            r_mod   <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    // zeroes counters and ages, one frame per cycle
                    if (r_i == CW'(FRAMES - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_IDLE: begin
                    if (cfg.valid) begin
                        if (cfg.payload.index == pre_pkg::REG_POLICY) begin
                            r_mode <= cfg.payload.data[pre_pkg::MODE_W-1:0];
                        end else begin
                            r_lfsr <= (cfg.payload.data == '0) ? pre_pkg::SEED_RST
                                                              : cfg.payload.data;
                        end
                    end
                    if (req.valid) begin
                        r_req  <= req.payload;
                        r_page <= PAGE_BITS'(req.payload.page_number);
                        r_i    <= '0;
                        r_rvld <= 1'b0;
                        if (req.payload.cmd == pre_pkg::CMD_TICK) begin
                            r_state <= S_TICK;
                        end else begin
                            r_state <= S_LOOK;
                        end
                    end
                end
                S_TICK: begin
                    // read frame r_i, write back the frame read last cycle
                    r_ridx <= r_i[FW-1:0];
                    r_rvld <= (r_i != CW'(FRAMES));
                    if (tick_clr && r_i != CW'(FRAMES)) begin
                        r_ref[r_i[FW-1:0]] <= 1'b0;
                    end
                    if (r_i == CW'(FRAMES)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_LOOK: begin
                    // RAM read issued for r_i; its data is checked next cycle
                    r_ridx <= r_i[FW-1:0];
                    r_rvld <= (r_i != CW'(FRAMES));
                    if (r_rvld && r_used[r_ridx] && ram_rdata == r_page) begin
                        r_f     <= r_ridx;
                        r_state <= S_HIT;
                    end else if (r_i == CW'(FRAMES)) begin
                        r_state <= S_FREE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_HIT: begin
                    // counter and age of the hit frame are read here
                    r_ref[r_f] <= 1'b1;
                    if (r_req.is_write) begin
                        r_mod[r_f] <= 1'b1;
                    end
                    r_state <= S_HITWR;
                end
                S_HITWR: begin
                    r_rsp.hit           <= 1'b1;
                    r_rsp.frame_index   <= pre_pkg::FRAME_W'(r_f);
                    r_rsp.evicted_valid <= 1'b0;
                    r_rsp.evicted_page  <= '0;
                    r_rsp.evicted_dirty <= 1'b0;
                    r_state <= S_OUT;
                end
                S_FREE: begin
                    r_i     <= '0;
                    r_rvld  <= 1'b0;
                    r_bany  <= 1'b0;
                    r_best  <= '0;
                    r_bcls  <= 2'd3;
                    r_bestv <= '1;
                    r_evict <= !free_any;
                    if (free_any) begin
                        r_f     <= free_idx;
                        r_state <= S_LOAD;
                    end else begin
                        case (r_mode)
                            pre_pkg::POL_FIFO: begin
                                r_f     <= r_hand;
                                r_hand  <= (r_hand == FW'(FRAMES - 1)) ? '0 : r_hand + 1'b1;
                                r_state <= S_RDOLD;
                            end
                            pre_pkg::POL_RANDOM: begin
                                r_lfsr  <= lfsr_nx;
                                r_f     <= FW'(lfsr_nx % FRAMES);
                                r_state <= S_RDOLD;
                            end
                            pre_pkg::POL_CLOCK: r_state <= S_CLOCK;
                            default: r_state <= S_VSCAN;
                        endcase
                    end
                end
                S_VSCAN: begin
                    if (is_nru) begin
                        if (r_i == CW'(FRAMES)) begin
                            r_f     <= r_best;
                            r_state <= S_RDOLD;
                        end else if (cur_cls == 2'd0) begin
                            r_f     <= r_i[FW-1:0];
                            r_state <= S_RDOLD;
                        end else begin
                            // later frame of same class, or any lower class, wins
                            if (!r_bany || cur_cls <= r_bcls) begin
                                r_best <= r_i[FW-1:0];
                                r_bcls <= cur_cls;
                                r_bany <= 1'b1;
                            end
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        // least value, first frame kept on a tie
                        r_ridx <= r_i[FW-1:0];
                        r_rvld <= (r_i != CW'(FRAMES));
                        if (r_rvld && (!r_bany || less)) begin
                            r_best  <= r_ridx;
                            r_bestv <= cur_v;
                            r_bany  <= 1'b1;
                        end
                        if (r_i == CW'(FRAMES)) begin
                            if (!r_rvld) begin
                                r_f     <= r_best;
                                r_state <= S_RDOLD;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_CLOCK: begin
                    if (r_ref[r_hand]) begin
                        r_ref[r_hand] <= 1'b0;
                    end else begin
                        r_f     <= r_hand;
                        r_state <= S_RDOLD;
                    end
                    r_hand <= (r_hand == FW'(FRAMES - 1)) ? '0 : r_hand + 1'b1;
                end
                S_RDOLD: begin
                    // tag read of the victim is issued here
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_used[r_f] <= 1'b1;
                    r_ref[r_f]  <= 1'b1;
                    r_mod[r_f]  <= r_req.is_write;
                    r_rsp.hit           <= 1'b0;
                    r_rsp.frame_index   <= pre_pkg::FRAME_W'(r_f);
                    r_rsp.evicted_valid <= r_evict;
                    r_rsp.evicted_page  <= r_evict ? pre_pkg::PAGE_W'(ram_rdata) : '0;
                    r_rsp.evicted_dirty <= r_evict & r_mod[r_f];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // no result is offered while an item can be taken
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid |-> !req.ready) else $error("result and input ready together");
    // a tick never yields a result
    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |=> !rsp.valid) else $error("tick produced a result");
    // LFSR never locks up at zero
    a_lfsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0) else $error("lfsr zero");
    // hit reports carry no eviction
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && rsp.payload.hit) |-> !rsp.payload.evicted_valid)
        else $error("hit with eviction");
`endif

endmodule

/* sim/testbench.sv */
`default_nettype none

// Checks the page replacement engine against a cycle-free model of its
// frame table. Accesses and ticks go in on req, results come back on rsp
// and are checked field by field in order. The policy and the seed are
// rewritten between phases, once the engine is idle.
class frame_table_model;
    logic        used [64];
    logic [15:0] page [64];
    logic        refd [64];
    logic        dirty [64];
    logic [7:0]  cnt [64];
    logic [31:0] age [64];
    logic [5:0]  hand;
    logic [15:0] lfsr;
    logic [2:0]  mode;
    pre_pkg::t_rsp pending_rsp [$];
    int mismatches;
    int n_access, n_tick, n_evict, n_hit;

    function new();
        for (int i = 0; i < 64; i++) begin
            used[i] = 0; page[i] = '0; refd[i] = 0; dirty[i] = 0;
            cnt[i] = '0; age[i] = '0;
        end
        hand = '0;
        lfsr = pre_pkg::SEED_RST;
        mode = pre_pkg::POL_NRU;
        mismatches = 0;
        n_access = 0; n_tick = 0; n_evict = 0; n_hit = 0;
    endfunction

    function void write_reg(logic [pre_pkg::IDX_W-1:0] idx, logic [15:0] data);
        if (idx == pre_pkg::REG_POLICY)
            mode = data[2:0];
        else
            lfsr = (data == 16'h0) ? 16'h1 : data;
    endfunction

    // NRU: first clean unreferenced frame, else last of the lowest class
    function int pick_nru();
        int last [4];
        int c;
        for (int k = 0; k < 4; k++) last[k] = -1;
        for (int i = 0; i < 64; i++) begin
            c = (refd[i] ? 2 : 0) + (dirty[i] ? 1 : 0);
            last[c] = i;
            if (c == 0) return i;
        end
        for (int k = 1; k < 4; k++)
            if (last[k] >= 0) return last[k];
        return 0;
    endfunction

    function int pick_victim();
        int best;
        int v;
        case (mode)
            pre_pkg::POL_COUNT: begin
                best = 0;
                for (int i = 1; i < 64; i++) if (cnt[i] < cnt[best]) best = i;
                return best;
            end
            pre_pkg::POL_AGING: begin
                best = 0;
                for (int i = 1; i < 64; i++) if (age[i] < age[best]) best = i;
                return best;
            end
            pre_pkg::POL_FIFO: begin
                v = hand;
                hand = hand + 6'd1;
                return v;
            end
            pre_pkg::POL_CLOCK: begin
                v = hand;
                while (refd[v]) begin
                    refd[v] = 0;
                    v = (v + 1) % 64;
                end
                hand = 6'((v + 1) % 64);
                return v;
            end
            pre_pkg::POL_RANDOM: begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ pre_pkg::LFSR_TAPS) : (lfsr >> 1);
                return lfsr[5:0];
            end
            default: return pick_nru();
        endcase
    endfunction

    function void note_item(pre_pkg::t_req r);
        pre_pkg::t_rsp e;
        int f;
        bit found;
        bit empty;
        if (r.cmd == pre_pkg::CMD_TICK) begin
            n_tick++;
            if (mode != pre_pkg::POL_FIFO && mode != pre_pkg::POL_RANDOM)
                for (int i = 0; i < 64; i++) begin
                    refd[i] = 0; cnt[i] = '0; age[i] = age[i] >> 1;
                end
            return;
        end
        n_access++;
        e = '0;
        f = 0; found = 0; empty = 0;
        for (int i = 0; i < 64; i++)
            if (!found && used[i] && page[i] == r.page_number) begin
                f = i; found = 1;
            end
        if (found) begin
            n_hit++;
            if (mode == pre_pkg::POL_COUNT) cnt[f] = cnt[f] + 8'd1;
            else if (mode == pre_pkg::POL_AGING) age[f] = (age[f] >> 1) | 32'h8000_0000;
            refd[f] = 1;
            if (r.is_write) dirty[f] = 1;
        end else begin
            for (int i = 0; i < 64; i++)
                if (!empty && !used[i]) begin
                    f = i; empty = 1;
                end
            if (!empty) begin
                f = pick_victim();
                n_evict++;
                e.evicted_valid = 1;
                e.evicted_page = page[f];
                e.evicted_dirty = dirty[f];
            end
            used[f] = 1; page[f] = r.page_number; refd[f] = 1;
            dirty[f] = r.is_write; cnt[f] = 8'd1; age[f] = 32'h8000_0000;
        end
        e.hit = found;
        e.frame_index = f[5:0];
        pending_rsp.push_back(e);
    endfunction

    function void check_result(pre_pkg::t_rsp a);
        pre_pkg::t_rsp e;
        if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result item %h", $time, a);
            mismatches++;
            return;
        end
        e = pending_rsp.pop_front();
        if (a.hit !== e.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.hit, a.hit);
            mismatches++;
        end
        if (a.frame_index !== e.frame_index) begin
            $display("%0t: frame_index exp %0d got %0d", $time, e.frame_index, a.frame_index);
            mismatches++;
        end
        if (a.evicted_valid !== e.evicted_valid) begin
            $display("%0t: evicted_valid exp %0d got %0d", $time,
                     e.evicted_valid, a.evicted_valid);
            mismatches++;
        end
        if (a.evicted_page !== e.evicted_page) begin
            $display("%0t: evicted_page exp %h got %h", $time, e.evicted_page, a.evicted_page);
            mismatches++;
        end
        if (a.evicted_dirty !== e.evicted_dirty) begin
            $display("%0t: evicted_dirty exp %0d got %0d", $time,
                     e.evicted_dirty, a.evicted_dirty);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 160;   // covers a tick sweep after the last result

    logic clk;
    logic rst_n;

    pre_req_if req_if ();
    pre_rsp_if rsp_if ();
    pre_cfg_if cfg_if ();

    page_replacement_engine_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .req     (req_if.sink),
        .rsp     (rsp_if.source),
        .cfg     (cfg_if.sink)
    );

    frame_table_model frames;

    int  hold_off_cycles = 0;   // long receiver stall, asked for by the stimulus
    bit  no_idle = 0;           // stretch with both sides running flat out
    int  idle_cycles = 0;
    logic [15:0] page_pool [80];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        frames = new();
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
    end

    // Monitor: results checked before the next access is noted
    always @(posedge clk) begin
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) frames.check_result(rsp_if.payload);
            if (req_if.valid && req_if.ready) frames.note_item(req_if.payload);
            if (cfg_if.valid && cfg_if.ready)
                frames.write_reg(cfg_if.payload.index, cfg_if.payload.data);
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Result receiver: random gap per item, plus the occasional long hold-off
    initial begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
            @(negedge clk);
        end
    end

    // Offers one item; entered and left at a falling edge
    task automatic send_item(input logic cmd, input logic [15:0] pg, input logic wr);
        int gap;
        pre_pkg::t_req r;
        r.cmd = cmd;
        r.page_number = pg;
        r.is_write = wr;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    // Drops valid, then waits out every outstanding result
    task automatic drain();
        req_if.valid <= 1'b0;
        while (frames.pending_rsp.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pre_pkg::IDX_W-1:0] idx, input logic [15:0] data);
        pre_pkg::t_cfg c;
        c.index = idx;
        c.data = data;
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= c;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Random accesses and ticks, mostly from a pool slightly larger than the table
    task automatic run_random(input int count);
        int sel;
        logic [15:0] pg;
        for (int i = 0; i < 80; i++) page_pool[i] = $urandom;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            pg = (sel < 10) ? 16'($urandom) : page_pool[$urandom_range(0, 79)];
            send_item((sel >= 92) ? pre_pkg::CMD_TICK : pre_pkg::CMD_ACCESS, pg,
                      1'($urandom));
        end
    endtask

    initial begin
        logic [2:0]  modes [12];
        logic [15:0] seeds [12];
        // codes six and seven are undefined and run as NRU
        modes = '{pre_pkg::POL_NRU, pre_pkg::POL_COUNT, pre_pkg::POL_AGING,
                  pre_pkg::POL_FIFO, pre_pkg::POL_CLOCK, pre_pkg::POL_RANDOM,
                  pre_pkg::POL_RANDOM, 3'd6, 3'd7, pre_pkg::POL_RANDOM,
                  pre_pkg::POL_CLOCK, pre_pkg::POL_COUNT};
        seeds = '{16'h0001, 16'hFFFF, 16'h1234, 16'h0001, 16'h8000, 16'h0000,
                  16'hFFFF, 16'h0001, 16'h5A5A, 16'($urandom), 16'h0001, 16'hACE1};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: free fills, page extremes, hits with and without writes, ticks
        send_item(pre_pkg::CMD_ACCESS, 16'h0000, 1'b1);
        send_item(pre_pkg::CMD_ACCESS, 16'hFFFF, 1'b0);
        send_item(pre_pkg::CMD_ACCESS, 16'h0000, 1'b0);
        send_item(pre_pkg::CMD_ACCESS, 16'hFFFF, 1'b1);
        send_item(pre_pkg::CMD_TICK,   16'hFFFF, 1'b1);
        send_item(pre_pkg::CMD_ACCESS, 16'hFFFF, 1'b0);
        send_item(pre_pkg::CMD_ACCESS, 16'hAAAA, 1'b0);
        send_item(pre_pkg::CMD_ACCESS, 16'h5555, 1'b1);
        send_item(pre_pkg::CMD_TICK,   16'h0000, 1'b0);
        send_item(pre_pkg::CMD_ACCESS, 16'h5555, 1'b0);

        for (int p = 0; p < 12; p++) begin
            drain();
            write_reg(pre_pkg::REG_POLICY, {13'h0, modes[p]});
            write_reg(pre_pkg::REG_SEED, seeds[p]);
            if (p == 3) no_idle = 1;
            if (p == 6) hold_off_cycles = 400;
            run_random(40);
            if (p == 4) begin
                // sender pauses until every result is back
                req_if.valid <= 1'b0;
                while (frames.pending_rsp.size() != 0) @(negedge clk);
            end
            run_random(40);
            no_idle = 0;
        end

        drain();
        $display("Run covered %0d accesses (%0d hits, %0d evictions) and %0d ticks",
                 frames.n_access, frames.n_hit, frames.n_evict, frames.n_tick);
        $display("over policy codes 0..7 and seeds including 0 and ffff");
        if (frames.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire
